/* rtl/lrrs_pkg.sv */
// Shared types, constants and codes for the zoned read request scheduler.
// Used by every module under rtl/ except lrrs_ram; depends on nothing.
`timescale 1ns / 1ps
package lrrs_pkg;

  localparam int ZONE_COUNT  = 32;
  localparam int TABLE_DEPTH = 64;
  localparam int LAST_ZONE   = ZONE_COUNT - 1;
  localparam int ZW          = $clog2(ZONE_COUNT + 1);   // zone code incl. FIFO code
  localparam int ZI_W        = $clog2(ZONE_COUNT);       // read zone index
  localparam int SW          = $clog2(TABLE_DEPTH);      // slot index
  localparam int CW          = $clog2(TABLE_DEPTH + 1);  // per-zone occupancy count
  localparam int ACC_W       = 32 + $clog2(ZONE_COUNT);  // zone boundary accumulator

  localparam logic CMD_ADD      = 1'b0;
  localparam logic CMD_DISPATCH = 1'b1;

  localparam logic REG_EXPIRY = 1'b0;
  localparam logic REG_SPAN   = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_NONE       = 2'd3
  } lrrs_status_t;

  typedef enum logic [1:0] {F_IDLE, F_DIV, F_PUSH} lrrs_fstate_t;

  typedef enum logic [2:0] {B_IDLE, B_EXEC, B_ZSRCH, B_SCAN, B_DECIDE, B_DONE} lrrs_bstate_t;

  typedef struct packed {
    logic          cmd;
    logic [31:0]   now;
    logic [7:0]    tag;
    logic [31:0]   sector;
    logic [ZW-1:0] zone;
    logic [31:0]   deadline;
  } lrrs_item_t;

  typedef struct packed {
    logic [31:0]   sector;
    logic [31:0]   deadline;
    logic [ZW-1:0] zone;
    logic [7:0]    tag;
    logic [31:0]   stamp;
  } lrrs_entry_t;

  typedef struct packed {
    logic decide;
    logic have;
    logic load;
  } lrrs_bstat_t;

endpackage

/* rtl/lrrs_ram.sv */
// Generic single write port RAM with one registered read port.
// No dependencies.
`timescale 1ns / 1ps
module lrrs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

/* rtl/lrrs_front.sv */
// Front end: accepts words, works out the sector zone and the deadline.
// Depends on lrrs_pkg; feeds lrrs_queue.
`timescale 1ns / 1ps
module lrrs_front import lrrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_cmd,
  input  logic [31:0] in_now,
  input  logic [7:0]  in_tag,
  input  logic [31:0] in_sector,
  input  logic        in_write,
  input  logic        in_sync,
  input  logic [15:0] expiry,
  input  logic [31:0] span,
  output logic        q_push,
  input  logic        q_ready,
  output lrrs_item_t  q_item
);
  lrrs_fstate_t state_r, state_nxt;
  lrrs_item_t   item_r;
  logic [ACC_W-1:0] acc_r;
  logic div_stop;

  assign div_stop = (span == 32'd0) || (item_r.zone == ZW'(LAST_ZONE)) ||
                    ({{(ACC_W-32){1'b0}}, item_r.sector} < acc_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          state_nxt = (in_cmd == CMD_ADD && !in_write && !in_sync) ? F_DIV : F_PUSH;
        end
      end
      F_DIV:  if (div_stop) state_nxt = F_PUSH;
      F_PUSH: if (q_ready) state_nxt = F_IDLE;
      default: state_nxt = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state_r == F_IDLE);
    q_push   = (state_r == F_PUSH);
    q_item   = item_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    unique case (state_r)
      F_IDLE: begin
        if (in_valid) begin
          item_r.cmd      <= in_cmd;
          item_r.now      <= in_now;
          item_r.tag      <= in_tag;
          item_r.sector   <= in_sector;
          item_r.zone     <= (in_write || in_sync) ? ZW'(ZONE_COUNT) : '0;
          item_r.deadline <= in_now + {16'd0, expiry};
          acc_r           <= {{(ACC_W-32){1'b0}}, span};
        end
      end
      F_DIV: begin
        // walk zone boundaries upward; a zero span means the last zone
        if (span == 32'd0) begin
          item_r.zone <= ZW'(LAST_ZONE);
        end else if (!div_stop) begin
          item_r.zone <= item_r.zone + 1'b1;
          acc_r       <= acc_r + {{(ACC_W-32){1'b0}}, span};
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/lrrs_queue.sv */
// Two-entry queue between the front end and the back end.
// Depends on lrrs_pkg.
`timescale 1ns / 1ps
module lrrs_queue import lrrs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  output logic       push_ready,
  input  lrrs_item_t push_item,
  output logic       pop_valid,
  input  logic       pop,
  output lrrs_item_t pop_item
);
  lrrs_item_t  mem_r [2];
  logic        wp_r, rp_r;
  logic [1:0]  cnt_r;
  logic        do_push, do_pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_item   = mem_r[rp_r];
  assign do_push    = push && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (do_push) wp_r <= ~wp_r;
      if (do_pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, do_push} - {1'b0, do_pop};
    end
    if (do_push) begin
      mem_r[wp_r] <= push_item;
    end
  end
endmodule

/* rtl/lrrs_back.sv */
// Back end: request table, zone search, slot scan and result register.
// Depends on lrrs_pkg and lrrs_ram.
`timescale 1ns / 1ps
module lrrs_back import lrrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  output logic        q_pop,
  input  lrrs_item_t  q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [7:0]  out_tag,
  output lrrs_bstat_t bstat
);
  lrrs_bstate_t state_r, state_nxt;
  lrrs_item_t   work_r;

  logic [TABLE_DEPTH-1:0] valid_r;
  logic [CW-1:0]          cnt_r [ZONE_COUNT+1];
  logic [31:0]            next_age_r;
  logic [ZI_W-1:0]        scan_start_r;
  logic [ZI_W-1:0]        z_r;
  logic [ZI_W-1:0]        k_r;
  logic [ZW-1:0]          target_r;

  logic [SW-1:0] issue_r, ri_r;
  logic          issuing_r, rv_r;

  logic          have_r;
  logic [SW-1:0] old_idx_r, low_idx_r;
  logic [31:0]   old_age_r, low_age_r, old_dl_r, low_sec_r;
  logic [7:0]    old_tag_r, low_tag_r;

  lrrs_status_t  res_status_r;
  logic [7:0]    res_tag_r;
  logic          out_valid_r;
  lrrs_status_t  out_status_r;
  logic [7:0]    out_tag_r;

  logic          free_ok;
  logic [SW-1:0] free_idx;
  logic          ram_we;
  lrrs_entry_t   wentry, rentry;
  logic [$bits(lrrs_entry_t)-1:0] rdata;
  logic [31:0]   age_e;
  logic          match, upd_old, upd_low, zone_hit, out_free, take_old;
  logic [31:0]   late;

  // lowest free slot
  always_comb begin
    free_ok  = 1'b0;
    free_idx = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_ok  = 1'b1;
        free_idx = SW'(i);
      end
    end
  end

  assign wentry = '{sector: work_r.sector, deadline: work_r.deadline, zone: work_r.zone,
                    tag: work_r.tag, stamp: next_age_r};
  assign ram_we = (state_r == B_EXEC) && (work_r.cmd == CMD_ADD) && free_ok;

  lrrs_ram #(.WIDTH($bits(lrrs_entry_t)), .DEPTH(TABLE_DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (free_idx),
    .wdata (wentry),
    .raddr (issue_r),
    .rdata (rdata)
  );

  assign rentry   = lrrs_entry_t'(rdata);
  assign age_e    = next_age_r - rentry.stamp;
  assign match    = rv_r && valid_r[ri_r] && (rentry.zone == target_r);
  assign upd_old  = match && (!have_r || age_e > old_age_r);
  assign upd_low  = match && (!have_r || rentry.sector < low_sec_r ||
                    (rentry.sector == low_sec_r && age_e > low_age_r));
  assign zone_hit = (cnt_r[ZW'(z_r)] != '0);
  assign out_free = !out_valid_r || out_ready;
  assign late     = work_r.now - old_dl_r;
  // FIFO entries always go oldest first; reads go oldest first once overdue
  assign take_old = (target_r == ZW'(ZONE_COUNT)) || !late[31];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (q_valid) state_nxt = B_EXEC;
      B_EXEC:   state_nxt = (work_r.cmd == CMD_ADD) ? B_DONE : B_ZSRCH;
      B_ZSRCH: begin
        if (zone_hit) begin
          state_nxt = B_SCAN;
        end else if (k_r == ZI_W'(LAST_ZONE)) begin
          state_nxt = (cnt_r[ZONE_COUNT] != '0) ? B_SCAN : B_DONE;
        end
      end
      B_SCAN:   if (rv_r && ri_r == SW'(TABLE_DEPTH - 1)) state_nxt = B_DECIDE;
      B_DECIDE: state_nxt = B_DONE;
      B_DONE:   if (out_free) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    q_pop        = (state_r == B_IDLE) && q_valid;
    bstat.decide = (state_r == B_DECIDE);
    bstat.have   = have_r;
    bstat.load   = (state_r == B_DONE) && out_free;
    out_valid    = out_valid_r;
    out_status   = out_status_r;
    out_tag      = out_tag_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      valid_r      <= '0;
      next_age_r   <= '0;
      scan_start_r <= '0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i <= ZONE_COUNT; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        B_EXEC: begin
          if (work_r.cmd == CMD_ADD && free_ok) begin
            valid_r[free_idx]    <= 1'b1;
            cnt_r[work_r.zone]   <= cnt_r[work_r.zone] + 1'b1;
            next_age_r           <= next_age_r + 32'd1;
          end
        end
        B_ZSRCH: if (zone_hit) scan_start_r <= z_r;
        B_DECIDE: begin
          valid_r[take_old ? old_idx_r : low_idx_r] <= 1'b0;
          cnt_r[target_r] <= cnt_r[target_r] - 1'b1;
        end
        default: ;
      endcase
    end

    unique case (state_r)
      B_IDLE: begin
        work_r <= q_item;
        z_r    <= scan_start_r;
        k_r    <= '0;
      end
      B_EXEC: begin
        res_tag_r    <= 8'd0;
        res_status_r <= free_ok ? ST_ADDED : ST_FULL;
      end
      B_ZSRCH: begin
        have_r    <= 1'b0;
        issue_r   <= '0;
        issuing_r <= 1'b1;
        rv_r      <= 1'b0;
        if (zone_hit) begin
          target_r <= ZW'(z_r);
        end else begin
          target_r     <= ZW'(ZONE_COUNT);
          z_r          <= (z_r == ZI_W'(LAST_ZONE)) ? '0 : z_r + 1'b1;
          k_r          <= k_r + 1'b1;
          res_status_r <= ST_NONE;
          res_tag_r    <= 8'd0;
        end
      end
      B_SCAN: begin
        if (issuing_r) begin
          if (issue_r == SW'(TABLE_DEPTH - 1)) issuing_r <= 1'b0;
          else issue_r <= issue_r + 1'b1;
        end
        rv_r <= issuing_r;
        ri_r <= issue_r;
        if (match) have_r <= 1'b1;
        if (upd_old) begin
          old_idx_r <= ri_r;
          old_age_r <= age_e;
          old_dl_r  <= rentry.deadline;
          old_tag_r <= rentry.tag;
        end
        if (upd_low) begin
          low_idx_r <= ri_r;
          low_age_r <= age_e;
          low_sec_r <= rentry.sector;
          low_tag_r <= rentry.tag;
        end
      end
      B_DECIDE: begin
        res_status_r <= ST_DISPATCHED;
        res_tag_r    <= take_old ? old_tag_r : low_tag_r;
      end
      B_DONE: begin
        if (out_free) begin
          out_status_r <= res_status_r;
          out_tag_r    <= res_tag_r;
        end
      end
      default: ;
    endcase
  end
endmodule

/* rtl/layered_read_request_scheduler.sv */
// Zoned deadline read scheduler: one result word per input word. For an add,
// writes and sync requests go straight to the queue, while for async reads the
// zone is found by stepping one zone boundary per cycle. A dispatch runs a
// circular zone search and then reads the table one slot per cycle through the
// RAM read port; a dispatch into an empty table ends after the search.
// A two-word queue between the front end and the back end lets the next word be
// taken while the current one is worked on; a finished result waits in the
// output register, and out_tready low holds the back end.
// Depends on lrrs_pkg, lrrs_front, lrrs_queue, lrrs_back.
`timescale 1ns / 1ps
module layered_read_request_scheduler import lrrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [79:0] in_tdata,   // now[31:0], request_tag[39:32], start_sector[71:40],
                                  // is_write[72], is_sync[73], zero[79:74]
  input  logic        in_tuser,   // command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // served_tag[7:0]
  output logic [1:0]  out_tuser,  // status[1:0]
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata
);
  logic [15:0] expiry_r;
  logic [31:0] span_r;
  logic        q_push, q_ready, q_valid, q_pop;
  lrrs_item_t  push_item, pop_item;
  lrrs_bstat_t bstat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      expiry_r <= 16'd1000;
      span_r   <= 32'd1601;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_EXPIRY: expiry_r <= cfg_wdata[15:0];
        REG_SPAN:   span_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lrrs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_cmd    (in_tuser),
    .in_now    (in_tdata[31:0]),
    .in_tag    (in_tdata[39:32]),
    .in_sector (in_tdata[71:40]),
    .in_write  (in_tdata[72]),
    .in_sync   (in_tdata[73]),
    .expiry    (expiry_r),
    .span      (span_r),
    .q_push    (q_push),
    .q_ready   (q_ready),
    .q_item    (push_item)
  );

  lrrs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_ready (q_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (pop_item)
  );

  lrrs_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .q_pop      (q_pop),
    .q_item     (pop_item),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_tag    (out_tdata),
    .bstat      (bstat)
  );

  // a zone picked by the occupancy counts must yield at least one entry
  a_decide_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.decide |-> bstat.have) else $error("dispatch found no entry in chosen zone");

  a_load_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
    bstat.load |=> out_tvalid) else $error("result not presented after load");

  a_dispatch_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_DISPATCHED |-> out_tdata == 8'd0)
    else $error("nonzero tag on non-dispatch result");

  a_push_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    q_push && !q_ready |=> q_push) else $error("queue push dropped");
endmodule

/* tb/layered_read_request_scheduler_chk.sv */
// Checker for the zoned deadline read scheduler: it watches the input, result
// and config ports, predicts each result word and compares it with the one seen.
// Depends on lrrs_pkg.
`timescale 1ns / 1ps
module layered_read_request_scheduler_chk import lrrs_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [79:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [7:0]  out_tdata,
  input  logic [1:0]  out_tuser,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  localparam logic [5:0] FIFO_ZONE = 6'(ZONE_COUNT);
  localparam logic [5:0] TOP_ZONE  = 6'(LAST_ZONE);

  logic        valid_q [TABLE_DEPTH];
  logic [31:0] sector_q [TABLE_DEPTH];
  logic [31:0] deadline_q [TABLE_DEPTH];
  logic [5:0]  zone_q [TABLE_DEPTH];
  logic [7:0]  tag_q [TABLE_DEPTH];
  logic [31:0] stamp_q [TABLE_DEPTH];
  logic [31:0] next_stamp;
  logic [4:0]  scan_zone;
  logic [15:0] expiry_ticks;
  logic [31:0] span_sectors;

  lrrs_status_t exp_status_q[$];
  logic [7:0]   exp_tag_q[$];

  assign pending = exp_status_q.size();

  function automatic int oldest_in_zone(logic [5:0] z);
    int best;
    best = -1;
    for (int s = 0; s < TABLE_DEPTH; s++)
      if (valid_q[s] && zone_q[s] == z)
        if (best < 0 || (next_stamp - stamp_q[s]) > (next_stamp - stamp_q[best])) best = s;
    return best;
  endfunction

  function automatic int lowest_in_zone(logic [5:0] z);
    int best;
    best = -1;
    for (int s = 0; s < TABLE_DEPTH; s++) begin
      if (!valid_q[s] || zone_q[s] != z) continue;
      if (best < 0 || sector_q[s] < sector_q[best] ||
          (sector_q[s] == sector_q[best] &&
           (next_stamp - stamp_q[s]) > (next_stamp - stamp_q[best])))
        best = s;
    end
    return best;
  endfunction

  // Apply one accepted word to the shadow table and queue its expected result.
  task automatic schedule_word(logic cmd, logic [31:0] now, logic [7:0] tag,
                               logic [31:0] sector, logic wr, logic sy);
    int slot;
    int pick;
    int old;
    logic [5:0] z;
    logic [31:0] q;
    logic [31:0] diff;
    logic found;
    slot = -1;
    pick = -1;
    found = 1'b0;
    if (cmd == CMD_ADD) begin
      for (int s = TABLE_DEPTH - 1; s >= 0; s--) if (!valid_q[s]) slot = s;
      if (slot < 0) begin
        exp_status_q.push_back(ST_FULL);
        exp_tag_q.push_back(8'd0);
        return;
      end
      if (wr || sy) z = FIFO_ZONE;
      else if (span_sectors == 32'd0) z = TOP_ZONE;
      else begin
        q = sector / span_sectors;
        z = (q >= 32'(LAST_ZONE)) ? TOP_ZONE : q[5:0];
      end
      valid_q[slot] = 1'b1;
      sector_q[slot] = sector;
      deadline_q[slot] = now + 32'(expiry_ticks);
      zone_q[slot] = z;
      tag_q[slot] = tag;
      stamp_q[slot] = next_stamp;
      next_stamp = next_stamp + 32'd1;
      exp_status_q.push_back(ST_ADDED);
      exp_tag_q.push_back(8'd0);
      return;
    end
    for (int k = 0; k < ZONE_COUNT && !found; k++) begin
      z = 6'((scan_zone + k) % ZONE_COUNT);
      old = oldest_in_zone(z);
      if (old >= 0) begin
        found = 1'b1;
        scan_zone = z[4:0];
        diff = now - deadline_q[old];
        pick = diff[31] ? lowest_in_zone(z) : old;
      end
    end
    if (pick < 0) pick = oldest_in_zone(FIFO_ZONE);
    if (pick < 0) begin
      exp_status_q.push_back(ST_NONE);
      exp_tag_q.push_back(8'd0);
    end else begin
      valid_q[pick] = 1'b0;
      exp_status_q.push_back(ST_DISPATCHED);
      exp_tag_q.push_back(tag_q[pick]);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < TABLE_DEPTH; s++) valid_q[s] = 1'b0;
      next_stamp = '0;
      scan_zone = '0;
      expiry_ticks = 16'd1000;
      span_sectors = 32'd1601;
      exp_status_q.delete();
      exp_tag_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_EXPIRY) expiry_ticks = cfg_wdata[15:0];
        else span_sectors = cfg_wdata;
      end
      if (out_tvalid && out_tready) begin
        if (exp_status_q.size() == 0) begin
          $error("unexpected result word: status %0d tag %0d", out_tuser, out_tdata);
          fail_count++;
        end else begin
          if (out_tuser != exp_status_q[0]) begin
            $error("status: expected %0d, got %0d", exp_status_q[0], out_tuser);
            fail_count++;
          end
          if (out_tdata != exp_tag_q[0]) begin
            $error("served_tag: expected %0d, got %0d", exp_tag_q[0], out_tdata);
            fail_count++;
          end
          void'(exp_status_q.pop_front());
          void'(exp_tag_q.pop_front());
        end
      end
      if (in_tvalid && in_tready)
        schedule_word(in_tuser, in_tdata[31:0], in_tdata[39:32], in_tdata[71:40],
                      in_tdata[72], in_tdata[73]);
    end
  end

endmodule

/* tb/layered_read_request_scheduler_tb.sv */
// Top of the scheduler testbench: clock, reset, stimulus and verdict.
// Depends on lrrs_pkg, the scheduler RTL and layered_read_request_scheduler_chk.
`timescale 1ns / 1ps
module layered_read_request_scheduler_tb;
  import lrrs_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [79:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          words_sent;
  int          table_fill;
  logic [31:0] tick;
  logic [31:0] span_now;

  layered_read_request_scheduler u_top (.*);

  layered_read_request_scheduler_chk u_chk (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("Test completed with failures");
    $finish;
  end

  always @(negedge clk)
    out_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Hold the word until it is taken; gaps only ever lower tvalid.
  task automatic send_word(logic cmd, logic [31:0] now, logic [7:0] tag,
                           logic [31:0] sector, logic wr, logic sy);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = cmd;
    in_tdata  = {6'b0, sy, wr, sector, tag, now};
    do @(posedge clk); while (!in_tready);
    words_sent++;
    if (cmd == CMD_ADD && table_fill < TABLE_DEPTH) table_fill++;
    if (cmd == CMD_DISPATCH && table_fill > 0) table_fill--;
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_tvalid = 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_addr = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  function automatic logic [31:0] pick_sector();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(3) * 100;           // repeated sectors force ties
      2: return span_now * $urandom_range(35) + $urandom_range(3);
      default: return 32'hFFFF_FFFF - $urandom_range(3);
    endcase
  endfunction

  task automatic random_word(logic force_add);
    logic cmd;
    int r;
    r = $urandom_range(99);
    tick = tick + $urandom_range(300);
    if (force_add) cmd = CMD_ADD;
    else if (table_fill < 40) cmd = (r < 60) ? CMD_ADD : CMD_DISPATCH;
    else cmd = (r < 35) ? CMD_ADD : CMD_DISPATCH;
    if ($urandom_range(19) == 0)
      send_word($urandom_range(1), $urandom, $urandom, $urandom, $urandom_range(1),
                $urandom_range(1));
    else
      send_word(cmd, tick, $urandom, pick_sector(), $urandom_range(3) == 0,
                $urandom_range(3) == 0);
  endtask

  task automatic run_phase(logic [15:0] expiry, logic [31:0] span, int mode, int count);
    drain_results();
    write_reg(REG_EXPIRY, {16'b0, expiry});
    write_reg(REG_SPAN, span);
    span_now = span;
    for (int i = 0; i < count; i++) begin
      if (mode < 0 && i % 60 == 0) begin
        case ((i / 60) % 4)
          0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
          1: begin send_idle_pct = 51; recv_stall_pct = 0;  end
          2: begin send_idle_pct = 0;  recv_stall_pct = 51; end
          default: begin send_idle_pct = 15; recv_stall_pct = 15; end
        endcase
      end
      if (i == count / 2) begin
        // fill past capacity to see the full-table response
        while (table_fill < TABLE_DEPTH) random_word(1'b1);
        random_word(1'b1);
        random_word(1'b1);
      end else random_word(1'b0);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = CMD_ADD;
    cfg_we = 1'b0;
    cfg_addr = REG_EXPIRY;
    cfg_wdata = '0;
    out_tready = 1'b0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    words_sent = 0;
    table_fill = 0;
    tick = 32'hFFFF_F000;
    span_now = 32'd1601;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty dispatch, zone extremes, FIFO kinds, deadlines across wrap
    send_word(CMD_DISPATCH, 32'd0, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_ADD, 32'hFFFF_FFFF, 8'hFF, 32'hFFFF_FFFF, 1'b0, 1'b0);
    send_word(CMD_ADD, 32'd0, 8'd1, 32'd0, 1'b0, 1'b0);
    send_word(CMD_ADD, 32'd5, 8'd2, 32'd1600, 1'b0, 1'b0);
    send_word(CMD_ADD, 32'd5, 8'd3, 32'd1601, 1'b0, 1'b0);
    send_word(CMD_ADD, 32'd5, 8'd4, 32'd1601, 1'b0, 1'b0);
    send_word(CMD_ADD, 32'd6, 8'd5, 32'd7, 1'b1, 1'b0);
    send_word(CMD_ADD, 32'd7, 8'd6, 32'd8, 1'b0, 1'b1);
    send_word(CMD_ADD, 32'd8, 8'd7, 32'd9, 1'b1, 1'b1);
    send_word(CMD_DISPATCH, 32'd10, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd2000, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd2000, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'h8000_0000, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd3, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd3, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd3, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd3, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd3, 8'd0, 32'd0, 1'b0, 1'b0);
    send_word(CMD_DISPATCH, 32'd3, 8'd0, 32'd0, 1'b0, 1'b0);

    run_phase(16'd0, 32'd1, 0, 370);
    run_phase(16'hFFFF, 32'hFFFF_FFFF, 1, 370);
    send_idle_pct = 0;
    drain_results();                 // hold the sender until all results are back
    run_phase(16'd50, 32'd0, 2, 370);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    run_phase(16'd300, 32'd100, 3, 370);
    run_phase(16'd1000, 32'd1601, -1, 400);

    drain_results();
    $display("Sent %0d words over five register settings (expiry 0..65535, span 0..max),",
             words_sent);
    $display("with full-table, empty-dispatch and deadline-wrap cases and mixed stalls.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* layered_read_request_scheduler.f */
rtl/lrrs_pkg.sv
rtl/lrrs_ram.sv
rtl/lrrs_front.sv
rtl/lrrs_queue.sv
rtl/lrrs_back.sv
rtl/layered_read_request_scheduler.sv
tb/layered_read_request_scheduler_chk.sv
tb/layered_read_request_scheduler_tb.sv
